// ===== rtl/ccp_pkg.sv =====
// shared types and constants for the calendar clock with tick prescaler
package ccp_pkg;

  localparam int unsigned TickW    = 10;
  localparam int unsigned RefreshW = 8;
  localparam int unsigned YearW    = 16;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned SecondW  = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // input item kinds
  localparam logic ActTick = 1'b0;
  localparam logic ActLoad = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTicksPerSecond   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCorrectionIntvl  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCorrectionOffset = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRefreshPeriod    = 2'd3;

  // configuration reset values
  localparam logic [TickW-1:0]    RstTicksPerSecond   = 10'd495;
  localparam logic [TickW-1:0]    RstCorrectionIntvl  = 10'd1000;
  localparam logic [TickW-1:0]    RstCorrectionOffset = 10'd5;
  localparam logic [RefreshW-1:0] RstRefreshPeriod    = 8'd20;

  // calendar reset values
  localparam logic [YearW-1:0]   RstYear   = 16'd2000;
  localparam logic [MonthW-1:0]  RstMonth  = 4'd1;
  localparam logic [DayW-1:0]    RstDay    = 5'd1;
  localparam logic [HourW-1:0]   RstHour   = 5'd0;
  localparam logic [MinuteW-1:0] RstMinute = 6'd0;
  localparam logic [SecondW-1:0] RstSecond = 6'd0;

  // calendar limits
  localparam logic [SecondW-1:0] LastSecond = 6'd59;
  localparam logic [MinuteW-1:0] LastMinute = 6'd59;
  localparam logic [HourW-1:0]   LastHour   = 5'd23;
  localparam logic [MonthW-1:0]  LastMonth  = 4'd12;
  localparam logic [MonthW-1:0]  FirstMonth = 4'd1;
  localparam logic [DayW-1:0]    FirstDay   = 5'd1;
  localparam logic [DayW-1:0]    LongMonth  = 5'd31;
  localparam logic [DayW-1:0]    ShortMonth = 5'd30;
  localparam logic [DayW-1:0]    LeapFeb    = 5'd29;
  localparam logic [DayW-1:0]    PlainFeb   = 5'd28;
  localparam logic [DayW-1:0]    BadMonth   = 5'd0;

  typedef struct packed {
    logic [TickW-1:0]    ticks_per_second;
    logic [TickW-1:0]    correction_interval;
    logic [TickW-1:0]    correction_offset;
    logic [RefreshW-1:0] refresh_period;
  } ccp_cfg_t;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } ccp_time_t;

  typedef struct packed {
    logic load;
    logic advance;
  } ccp_cal_ctrl_t;

  typedef struct packed {
    logic second;
    logic refresh;
  } ccp_pulse_t;

endpackage

// ===== rtl/calendar_clock_with_tick_prescaler_top.sv =====
// top level: calendar clock with tick prescaler, refresh divider and config port
// path: an accepted item goes from the input reg to the result reg, which drives
// the result ports; throughput: one item per cycle while the output side does
// not stall, set by the single pass from input reg to result reg
// stall from the output side reaches the input stall in the same cycle
// reset (async, active low): config regs to their defaults, counters to zero,
// calendar to 2000-01-01 00:00:00, both item registers empty
module calendar_clock_with_tick_prescaler_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input item channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [ccp_pkg::YearW-1:0]    set_year_i,
  input  logic [ccp_pkg::MonthW-1:0]   set_month_i,
  input  logic [ccp_pkg::DayW-1:0]     set_day_i,
  input  logic [ccp_pkg::HourW-1:0]    set_hour_i,
  input  logic [ccp_pkg::MinuteW-1:0]  set_minute_i,
  input  logic [ccp_pkg::SecondW-1:0]  set_second_i,
  // result item channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         second_pulse_o,
  output logic                         refresh_pulse_o,
  output logic [ccp_pkg::YearW-1:0]    cur_year_o,
  output logic [ccp_pkg::MonthW-1:0]   cur_month_o,
  output logic [ccp_pkg::DayW-1:0]     cur_day_o,
  output logic [ccp_pkg::HourW-1:0]    cur_hour_o,
  output logic [ccp_pkg::MinuteW-1:0]  cur_minute_o,
  output logic [ccp_pkg::SecondW-1:0]  cur_second_o,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ccp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ccp_pkg::CfgDataW-1:0] cfg_data_i
);
  import ccp_pkg::*;

  // configuration registers
  ccp_cfg_t cfg_q;

  // input register
  logic      in_valid_q;
  logic      action_q;
  ccp_time_t set_q;

  // result register
  logic       out_valid_q;
  ccp_pulse_t res_pulse_q;
  ccp_time_t  res_time_q;

  // stage control
  logic          res_free;   // result reg empty or being taken this cycle
  logic          fire;       // item moves from input reg to result reg
  logic          tick;
  ccp_pulse_t    pulse;
  ccp_cal_ctrl_t cal_ctrl;
  ccp_time_t     cal_time_q;
  ccp_time_t     cal_time_d;

  assign res_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && res_free;
  assign tick       = fire && (action_q == ActTick);
  assign in_stall_o = in_valid_q && !res_free;

  // config writes are always taken; the user must issue them only while idle, the block itself does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_second    <= RstTicksPerSecond;
      cfg_q.correction_interval <= RstCorrectionIntvl;
      cfg_q.correction_offset   <= RstCorrectionOffset;
      cfg_q.refresh_period      <= RstRefreshPeriod;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgTicksPerSecond:   cfg_q.ticks_per_second    <= cfg_data_i;
        CfgCorrectionIntvl:  cfg_q.correction_interval <= cfg_data_i;
        CfgCorrectionOffset: cfg_q.correction_offset   <= cfg_data_i;
        CfgRefreshPeriod:    cfg_q.refresh_period      <= cfg_data_i[RefreshW-1:0];
        default: ;
      endcase
    end
  end

  // input register: loads whenever it is empty or its item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      action_q      <= action_i;
      set_q.year    <= set_year_i;
      set_q.month   <= set_month_i;
      set_q.day     <= set_day_i;
      set_q.hour    <= set_hour_i;
      set_q.minute  <= set_minute_i;
      set_q.second  <= set_second_i;
    end
  end

  // prescaler and refresh divider step only on a tick item
  ccp_tick_div u_tick_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick),
    .cfg_i   (cfg_q),
    .pulse_o (pulse)
  );

  // load item overwrites the calendar, a completed second advances it
  assign cal_ctrl.load    = fire && (action_q == ActLoad);
  assign cal_ctrl.advance = pulse.second;

  ccp_calendar u_calendar (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (cal_ctrl),
    .set_i    (set_q),
    .time_q_o (cal_time_q),
    .time_d_o (cal_time_d)
  );

  // result register: holds while the output side stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_pulse_q <= pulse;
      res_time_q  <= cal_time_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign second_pulse_o  = res_pulse_q.second;
  assign refresh_pulse_o = res_pulse_q.refresh;
  assign cur_year_o      = res_time_q.year;
  assign cur_month_o     = res_time_q.month;
  assign cur_day_o       = res_time_q.day;
  assign cur_hour_o      = res_time_q.hour;
  assign cur_minute_o    = res_time_q.minute;
  assign cur_second_o    = res_time_q.second;

  // a load item carries no pulses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_ctrl.load |=> !res_pulse_q.second && !res_pulse_q.refresh)
    else $error("pulse reported for a load item");

  // a load item shows exactly the loaded time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_ctrl.load |=> res_time_q == $past(set_q))
    else $error("loaded time not reported");

  // a tick that completes no second leaves the calendar alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick && !pulse.second |=> cal_time_q == $past(cal_time_q))
    else $error("calendar moved without a second");

  // the input side is only stalled by a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && in_valid_q)
    else $error("input stalled without a held result");

endmodule

// ===== rtl/ccp_tick_div.sv =====
// tick prescaler with periodic correction and refresh divider
module ccp_tick_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_i,
  input  ccp_pkg::ccp_cfg_t  cfg_i,
  output ccp_pkg::ccp_pulse_t pulse_o
);
  import ccp_pkg::*;

  logic [TickW-1:0]    tick_q, tick_d;
  logic [TickW-1:0]    corr_q, corr_d;
  logic [RefreshW-1:0] refr_q, refr_d;

  logic [TickW:0]    tick_inc;
  logic [TickW:0]    corr_inc;
  logic [RefreshW:0] refr_inc;
  logic              sec_hit;
  logic              corr_hit;
  logic              refr_hit;

  // increments are one bit wider so a counter at its maximum always fires
  assign tick_inc = {1'b0, tick_q} + 1'b1;
  assign corr_inc = {1'b0, corr_q} + 1'b1;
  assign refr_inc = {1'b0, refr_q} + 1'b1;

  assign sec_hit  = tick_inc >= {1'b0, cfg_i.ticks_per_second};
  assign corr_hit = corr_inc >= {1'b0, cfg_i.correction_interval};
  assign refr_hit = refr_inc >= {1'b0, cfg_i.refresh_period};

  always_comb begin
    tick_d = tick_q;
    corr_d = corr_q;
    refr_d = refr_q;
    if (tick_i) begin
      if (sec_hit) begin
        if (corr_hit) begin
          tick_d = cfg_i.correction_offset;
          corr_d = '0;
        end else begin
          tick_d = '0;
          corr_d = corr_inc[TickW-1:0];
        end
      end else begin
        tick_d = tick_inc[TickW-1:0];
      end
      refr_d = refr_hit ? '0 : refr_inc[RefreshW-1:0];
    end
  end

  assign pulse_o.second  = tick_i & sec_hit;
  assign pulse_o.refresh = tick_i & refr_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      corr_q <= '0;
      refr_q <= '0;
    end else begin
      tick_q <= tick_d;
      corr_q <= corr_d;
      refr_q <= refr_d;
    end
  end

endmodule

// ===== rtl/ccp_calendar.sv =====
// second/minute/hour/day/month/year calendar registers
module ccp_calendar (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ccp_pkg::ccp_cal_ctrl_t ctrl_i,
  input  ccp_pkg::ccp_time_t    set_i,
  output ccp_pkg::ccp_time_t    time_q_o,
  output ccp_pkg::ccp_time_t    time_d_o
);
  import ccp_pkg::*;

  ccp_time_t       time_q, time_d;
  logic [DayW-1:0] month_len;

  function automatic logic [DayW-1:0] month_length(input logic [YearW-1:0] y,
                                                   input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LongMonth;
        4'd4, 4'd6, 4'd9, 4'd11:                   len = ShortMonth;
        4'd2:    len = (y[1:0] == 2'b00) ? LeapFeb : PlainFeb;
        default: len = BadMonth;
      endcase
      return len;
    end
  endfunction

  assign month_len = month_length(time_q.year, time_q.month);

  always_comb begin
    time_d = time_q;
    if (ctrl_i.load) begin
      time_d = set_i;
    end else if (ctrl_i.advance) begin
      if (time_q.second < LastSecond) begin
        time_d.second = time_q.second + 1'b1;
      end else begin
        time_d.second = '0;
        if (time_q.minute < LastMinute) begin
          time_d.minute = time_q.minute + 1'b1;
        end else begin
          time_d.minute = '0;
          if (time_q.hour < LastHour) begin
            time_d.hour = time_q.hour + 1'b1;
          end else begin
            time_d.hour = '0;
            if (month_len > time_q.day) begin
              time_d.day = time_q.day + 1'b1;
            end else begin
              time_d.day = FirstDay;
              if (time_q.month >= LastMonth) begin
                time_d.month = FirstMonth;
                time_d.year  = time_q.year + 1'b1;
              end else begin
                time_d.month = time_q.month + 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q.year   <= RstYear;
      time_q.month  <= RstMonth;
      time_q.day    <= RstDay;
      time_q.hour   <= RstHour;
      time_q.minute <= RstMinute;
      time_q.second <= RstSecond;
    end else begin
      time_q <= time_d;
    end
  end

  assign time_q_o = time_q;
  assign time_d_o = time_d;

endmodule
